[sv/vbie_pkg.sv]
`default_nettype none

package vbie_pkg;

	// default sizes handed to the top level parameters
	localparam int MAX_KEYS_DEF  = 16;
	localparam int KEY_BYTES_DEF = 8;

	// fixed geometry of slots and bitmap words
	localparam int MAX_SLOTS     = 1024;
	localparam int WORD_W        = 64;
	localparam int WORD_LOG2     = $clog2(WORD_W);
	localparam int WORDS_PER_KEY = MAX_SLOTS / WORD_W;
	localparam int WSEL_W        = $clog2(WORDS_PER_KEY);
	localparam int PCNT_W        = $clog2(WORD_W + 1);

	// field widths
	localparam int ACT_W     = 2;
	localparam int KEY_W     = 64;
	localparam int LEN_W     = 4;
	localparam int SLOT_W    = 10;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 11;
	localparam int LIMIT_W   = 5;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = LIMIT_W'(16);

	// the two fixed keys of bool mode
	localparam logic [KEY_W-1:0] BOOL_KEY_F = KEY_W'(8'h00);
	localparam logic [KEY_W-1:0] BOOL_KEY_T = KEY_W'(8'h01);

	typedef enum logic [ACT_W-1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_TEST  = 2'd2,
		ACT_COUNT = 2'd3
	} vbie_act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_SLOT = 2'd1,
		STAT_REJECT   = 2'd2
	} vbie_stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VALUE_LIMIT = 2'd0,
		REG_SLOT_COUNT  = 2'd1,
		REG_BOOL_MODE   = 2'd2
	} vbie_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_RMW,
		ST_COUNT,
		ST_OUT
	} vbie_state_t;

	// dictionary lookup status toward the sequencer
	typedef struct packed {
		logic hit;
		logic full;
	} vbie_look_t;

	// keep only the valid key bytes
	function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (LEN_W'(b) < len) begin
				m[8*b +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	// number of set bits in one bitmap word: per-byte counts, then an adder tree
	function automatic logic [PCNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
		logic [3:0] part [8];
		logic [4:0] half [4];
		logic [5:0] quad [2];
		for (int b = 0; b < 8; b++) begin
			part[b] = '0;
			for (int i = 0; i < 8; i++) begin
				part[b] = part[b] + 4'(w[8*b + i]);
			end
		end
		for (int j = 0; j < 4; j++) begin
			half[j] = 5'(part[2*j]) + 5'(part[2*j + 1]);
		end
		for (int k = 0; k < 2; k++) begin
			quad[k] = 6'(half[2*k]) + 6'(half[2*k + 1]);
		end
		return PCNT_W'(quad[0]) + PCNT_W'(quad[1]);
	endfunction

endpackage

`default_nettype wire

[sv/vbie_dict.sv]
`default_nettype none

module vbie_dict #(
	parameter int MAX_KEYS  = vbie_pkg::MAX_KEYS_DEF,
	parameter int KEY_BYTES = vbie_pkg::KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [vbie_pkg::KEY_W-1:0]    key,
	input  logic [vbie_pkg::LEN_W-1:0]    len,
	input  logic                          bool_mode,
	input  logic [vbie_pkg::LIMIT_W-1:0]  value_limit,
	input  logic                          append,
	output vbie_pkg::vbie_look_t          look,
	output logic [$clog2(MAX_KEYS)-1:0]   idx
);
	import vbie_pkg::*;

	localparam int IW   = $clog2(MAX_KEYS);
	localparam int KCW  = $clog2(MAX_KEYS + 1);
	localparam int KW   = 8 * KEY_BYTES;
	localparam int CMPW = (KCW > LIMIT_W) ? KCW : LIMIT_W;

	logic [KW-1:0]    dict_key_q [MAX_KEYS];
	logic [LEN_W-1:0] dict_len_q [MAX_KEYS];
	logic [KCW-1:0]   key_count_q;

	logic [KEY_W-1:0]    mkey;
	logic                len_ok;
	logic [MAX_KEYS-1:0] match;
	logic [IW-1:0]       match_idx;
	logic                is_f;
	logic                is_t;

	// masked key and length check
	always_comb begin
		mkey   = key & byte_mask(len);
		len_ok = (len <= LEN_W'(KEY_BYTES));
		is_f   = (len == LEN_W'(1)) && (mkey == BOOL_KEY_F);
		is_t   = (len == LEN_W'(1)) && (mkey == BOOL_KEY_T);
	end

	// compare against every filled entry
	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			match[i] = len_ok && (KCW'(i) < key_count_q) && (dict_len_q[i] == len) &&
				(dict_key_q[i] == mkey[KW-1:0]);
		end
	end

	// lowest matching entry
	always_comb begin
		match_idx = '0;
		for (int i = MAX_KEYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_idx = IW'(i);
			end
		end
	end

	// lookup result; outside bool mode a miss points at the next free entry
	always_comb begin
		look.full = bool_mode || !len_ok ||
			(CMPW'(key_count_q) >= CMPW'(value_limit)) ||
			(key_count_q >= KCW'(MAX_KEYS));
		if (bool_mode) begin
			look.hit = is_f || is_t;
			idx      = is_t ? IW'(1) : '0;
		end else begin
			look.hit = |match;
			idx      = (|match) ? match_idx : key_count_q[IW-1:0];
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (append) begin
			dict_key_q[key_count_q[IW-1:0]] <= mkey[KW-1:0];
			dict_len_q[key_count_q[IW-1:0]] <= len;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (append) begin
			key_count_q <= key_count_q + KCW'(1);
		end
	end

endmodule

`default_nettype wire

[sv/value_bitmap_index_engine.sv]
`default_nettype none

// Bitmap index over record slots. Each item sets, clears or tests one slot bit
// in the bitmap of its value key, or counts the bits of that bitmap; keys are
// looked up in a small dictionary and a set of an unknown key appends it. The
// bitmaps live in one single-port-read memory of MAX_KEYS*16 words of 64 bits
// with registered read data, and one item is worked on at a time. Set, clear
// and test go through accept, dictionary match and word read,
// read-modify-write and output load; a rejected or bad-slot item and an
// unknown key go through accept, match and output load only; a count reads
// its key's 16 words one per cycle. After reset the memory is swept to zero,
// one word per cycle, through all MAX_KEYS*16 words (256 at the default size)
// with in_stall high; config writes are taken during the sweep. cfg_ready is always high.
module value_bitmap_index_engine #(
	parameter int MAX_KEYS  = vbie_pkg::MAX_KEYS_DEF,
	parameter int KEY_BYTES = vbie_pkg::KEY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [vbie_pkg::ACT_W-1:0]      action,
	input  logic [vbie_pkg::KEY_W-1:0]      value_key,
	input  logic [vbie_pkg::LEN_W-1:0]      value_len,
	input  logic [vbie_pkg::SLOT_W-1:0]     slot,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vbie_pkg::STAT_W-1:0]     status,
	output logic                            bit_value,
	output logic [vbie_pkg::CNT_W-1:0]      set_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vbie_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vbie_pkg::CFG_W-1:0]      cfg_data
);
	import vbie_pkg::*;

	localparam int IW          = $clog2(MAX_KEYS);
	localparam int AW          = IW + WSEL_W;
	localparam int TOTAL_WORDS = MAX_KEYS * WORDS_PER_KEY;

	vbie_state_t state_q, state_nxt;

	// configuration
	logic [LIMIT_W-1:0] value_limit_q;
	logic [CNT_W-1:0]   slot_count_q;
	logic               bool_mode_q;
	logic [CNT_W-1:0]   slot_wr;

	// item under work
	logic [ACT_W-1:0]  action_q;
	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] slot_q;

	// dictionary
	vbie_look_t    look;
	logic [IW-1:0] dict_idx;
	logic          append;

	// bitmap memory
	logic [WORD_W-1:0] bitmap_mem [TOTAL_WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [AW-1:0]     clr_addr_q;

	// sequencing and results
	logic              is_count;
	logic              slot_bad;
	logic              new_key;
	logic              use_idx;
	logic [AW-1:0]     match_addr;
	logic [AW-1:0]     addr_q;
	logic [WSEL_W-1:0] walk_q;
	logic [WSEL_W-1:0] walk_nxt;
	logic              walk_last;
	logic [WORD_W-1:0] bit_mask;
	vbie_stat_t        res_status_q;
	logic              res_bit_q;
	logic [CNT_W-1:0]  res_count_q;
	logic              out_load;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              bit_value_q;
	logic [CNT_W-1:0]  set_count_q;

	vbie_dict #(
		.MAX_KEYS  (MAX_KEYS),
		.KEY_BYTES (KEY_BYTES)
	) u_dict (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key_q),
		.len         (len_q),
		.bool_mode   (bool_mode_q),
		.value_limit (value_limit_q),
		.append      (append),
		.look        (look),
		.idx         (dict_idx)
	);

	// slot count only rises and saturates at the slot capacity
	always_comb begin
		slot_wr = (cfg_data > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_data;
	end

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_limit_q <= VALUE_LIMIT_RST;
			slot_count_q  <= CNT_W'(MAX_SLOTS);
			bool_mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VALUE_LIMIT: begin
					value_limit_q <= cfg_data[LIMIT_W-1:0];
				end
				REG_SLOT_COUNT: begin
					if (slot_wr > slot_count_q) begin
						slot_count_q <= slot_wr;
					end
				end
				REG_BOOL_MODE: begin
					bool_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// item decode in the match cycle
	always_comb begin
		is_count   = (action_q == ACT_COUNT);
		slot_bad   = !is_count && (CNT_W'(slot_q) >= slot_count_q);
		new_key    = !look.hit && (action_q == ACT_SET) && !slot_bad;
		use_idx    = look.hit || (new_key && !look.full);
		match_addr = {dict_idx, is_count ? WSEL_W'(0) : slot_q[SLOT_W-1:WORD_LOG2]};
		walk_nxt   = walk_q + WSEL_W'(1);
		walk_last  = (walk_q == WSEL_W'(WORDS_PER_KEY - 1));
		bit_mask   = WORD_W'(1) << slot_q[WORD_LOG2-1:0];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(TOTAL_WORDS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (is_count) begin
					state_nxt = look.hit ? ST_COUNT : ST_OUT;
				end else if (use_idx && !slot_bad) begin
					state_nxt = ST_RMW;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_RMW: begin
				state_nxt = ST_OUT;
			end
			ST_COUNT: begin
				if (walk_last) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// per-state controls
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		append    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_MATCH: begin
				append    = new_key && !look.full;
				mem_re    = use_idx && !slot_bad;
				mem_raddr = match_addr;
			end
			ST_RMW: begin
				mem_we    = (action_q == ACT_SET) || (action_q == ACT_CLEAR);
				mem_wdata = (action_q == ACT_SET) ? (rd_data_q | bit_mask) :
					(rd_data_q & ~bit_mask);
			end
			ST_COUNT: begin
				mem_re    = !walk_last;
				mem_raddr = {addr_q[AW-1:WSEL_W], walk_nxt};
			end
			ST_OUT: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= bitmap_mem[mem_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture and result build
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_q <= action;
			key_q    <= value_key;
			len_q    <= value_len;
			slot_q   <= slot;
		end
		case (state_q)
			ST_MATCH: begin
				addr_q      <= match_addr;
				walk_q      <= '0;
				res_bit_q   <= 1'b0;
				res_count_q <= '0;
				if (slot_bad) begin
					res_status_q <= STAT_BAD_SLOT;
				end else if (new_key && look.full) begin
					res_status_q <= STAT_REJECT;
				end else begin
					res_status_q <= STAT_OK;
				end
			end
			ST_RMW: begin
				if (action_q == ACT_TEST) begin
					res_bit_q <= rd_data_q[slot_q[WORD_LOG2-1:0]];
				end
			end
			ST_COUNT: begin
				res_count_q <= res_count_q + CNT_W'(popcount(rd_data_q));
				walk_q      <= walk_nxt;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			status_q    <= res_status_q;
			bit_value_q <= res_bit_q;
			set_count_q <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bit_value = bit_value_q;
	assign set_count = set_count_q;

`ifndef SYNTHESIS
	// the count walk only reads
	a_count_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COUNT) |-> !mem_we)
		else $error("bitmap write during count walk");

	// a modify always follows its own word read
	a_rmw_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> $past(mem_re))
		else $error("read-modify-write without a preceding read");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while one is in work");

	// a count never exceeds the slot capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (set_count_q <= CNT_W'(MAX_SLOTS)))
		else $error("set count above slot capacity");

	// a set bit is only reported with good status
	a_bit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bit_value_q) |-> (status_q == STAT_OK))
		else $error("tested bit reported with error status");
`endif

endmodule

`default_nettype wire

[sim/vbie_checker.sv]
`timescale 1ns / 100ps

module vbie_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [vbie_pkg::ACT_W-1:0]      action,
	input  logic [vbie_pkg::KEY_W-1:0]      value_key,
	input  logic [vbie_pkg::LEN_W-1:0]      value_len,
	input  logic [vbie_pkg::SLOT_W-1:0]     slot,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [vbie_pkg::STAT_W-1:0]     status,
	input  logic                            bit_value,
	input  logic [vbie_pkg::CNT_W-1:0]      set_count,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [vbie_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vbie_pkg::CFG_W-1:0]      cfg_data,
	output int unsigned                     results_seen,
	output int unsigned                     fails
);
	import vbie_pkg::*;

	localparam int KEYS = MAX_KEYS_DEF;
	localparam int NO_ENTRY = -1;

	typedef struct {
		vbie_stat_t       status;
		logic             bit_value;
		logic [CNT_W-1:0] count;
	} outcome_t;

	// predicted results still owed by the block, oldest first
	outcome_t outcome_q [$];

	// own copy of the dictionary, the slot bitmaps and the registers
	logic [KEY_W-1:0]     known_key [KEYS];
	logic [LEN_W-1:0]     known_len [KEYS];
	logic [MAX_SLOTS-1:0] slot_bits [KEYS];
	int unsigned          n_known;
	logic [LIMIT_W-1:0]   key_limit;
	logic [CFG_W-1:0]     slots_in_use;
	logic                 bool_on;

	int unsigned miss_count = 0;
	int unsigned seen_count = 0;

	assign fails = miss_count;
	assign results_seen = seen_count;

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		miss_count++;
	endtask

	// zero the key bytes at and above the length
	function automatic logic [KEY_W-1:0] valid_bytes(input logic [KEY_W-1:0] key,
			input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] keep;
		keep = (len >= 8) ? '1 : ((KEY_W'(1) << (8 * len)) - KEY_W'(1));
		return key & keep;
	endfunction

	// dictionary index of a key, or no entry
	function automatic int find_entry(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] k;
		k = valid_bytes(key, len);
		if (len > KEY_BYTES_DEF) return NO_ENTRY;
		if (bool_on) begin
			if (len != 1) return NO_ENTRY;
			if (k == BOOL_KEY_F) return 0;
			if (k == BOOL_KEY_T) return 1;
			return NO_ENTRY;
		end
		for (int i = 0; i < n_known && i < KEYS; i++) begin
			if (known_len[i] == len && known_key[i] == k) return i;
		end
		return NO_ENTRY;
	endfunction

	// advance the index by one item and return its result
	function automatic outcome_t apply_item(input vbie_act_t act, input logic [KEY_W-1:0] key,
			input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] pos);
		outcome_t r;
		int idx;
		r.status = STAT_OK;
		r.bit_value = 1'b0;
		r.count = '0;
		idx = find_entry(key, len);
		if (act == ACT_COUNT) begin
			if (idx != NO_ENTRY) r.count = CNT_W'($countones(slot_bits[idx]));
		end else if (CFG_W'(pos) >= slots_in_use) begin
			r.status = STAT_BAD_SLOT;
		end else begin
			// a set of an unknown key tries to append it
			if (idx == NO_ENTRY && act == ACT_SET) begin
				if (bool_on || len > KEY_BYTES_DEF || n_known >= key_limit || n_known >= KEYS) begin
					r.status = STAT_REJECT;
				end else begin
					idx = n_known;
					known_key[idx] = valid_bytes(key, len);
					known_len[idx] = len;
					n_known++;
				end
			end
			if (idx != NO_ENTRY) begin
				case (act)
					ACT_SET:   slot_bits[idx][pos] = 1'b1;
					ACT_CLEAR: slot_bits[idx][pos] = 1'b0;
					default:   r.bit_value = slot_bits[idx][pos];
				endcase
			end
		end
		return r;
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		logic [CFG_W-1:0] want_slots;
		want_slots = (data > MAX_SLOTS) ? CFG_W'(MAX_SLOTS) : data;
		case (idx)
			REG_VALUE_LIMIT: key_limit = data[LIMIT_W-1:0];
			REG_SLOT_COUNT:  if (want_slots > slots_in_use) slots_in_use = want_slots;
			REG_BOOL_MODE:   bool_on = data[0];
			default:         ;
		endcase
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < KEYS; i++) begin
				known_key[i] = '0;
				known_len[i] = '0;
				slot_bits[i] = '0;
			end
			n_known = 0;
			key_limit = VALUE_LIMIT_RST;
			slots_in_use = CFG_W'(MAX_SLOTS);
			bool_on = 1'b0;
			outcome_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
			// results are matched before this edge's item is predicted
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					report("result with nothing pending", 16'(status), 16'(0));
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) report("status", 16'(status), 16'(want.status));
					if (bit_value !== want.bit_value)
						report("bit_value", 16'(bit_value), 16'(want.bit_value));
					if (set_count !== want.count)
						report("set_count", 16'(set_count), 16'(want.count));
				end
				seen_count <= seen_count + 1;
			end
			if (in_valid && !in_stall)
				outcome_q.push_back(apply_item(vbie_act_t'(action), value_key, value_len, slot));
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import vbie_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 250;
	localparam int TAIL_CYCLES  = 40;
	localparam int POOL_SIZE    = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ACT_W-1:0]     action = ACT_SET;
	logic [KEY_W-1:0]     value_key = '0;
	logic [LEN_W-1:0]     value_len = '0;
	logic [SLOT_W-1:0]    slot = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STAT_W-1:0]    status;
	logic                 bit_value;
	logic [CNT_W-1:0]     set_count;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int unsigned results_seen;
	int unsigned fails;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_off = 1'b0;

	// keys reused across items so the dictionary gets hits
	logic [KEY_W-1:0] pool_key [POOL_SIZE];
	logic [LEN_W-1:0] pool_len [POOL_SIZE];

	value_bitmap_index_engine dut (.*);

	vbie_checker chk (.*);

	always #6 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// fill the ignored bytes with noise
	function automatic logic [KEY_W-1:0] scramble_tail(input logic [KEY_W-1:0] key,
			input logic [LEN_W-1:0] len);
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (b >= len) key[8*b +: 8] = 8'($urandom_range(0, 255));
		end
		return key;
	endfunction

	function automatic vbie_act_t pick_action();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) return ACT_SET;
		if (r < 55) return ACT_CLEAR;
		if (r < 85) return ACT_TEST;
		return ACT_COUNT;
	endfunction

	// word edges and range ends get hit often
	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(0, 1)) return SLOT_W'($urandom);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 63;
			3: return 64;
			4: return 511;
			5: return 512;
			6: return 1000;
			default: return 1023;
		endcase
	endfunction

	task automatic send(input vbie_act_t act, input logic [KEY_W-1:0] key,
			input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] pos);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value_key <= key;
		value_len <= len;
		slot <= pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_random(input bit bool_bias);
		int unsigned r;
		int unsigned p;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, POOL_SIZE - 1);
		if (bool_bias && r < 70) begin
			len = 1;
			key = scramble_tail(KEY_W'($urandom_range(0, 1)), len);
		end else if (r < 85) begin
			len = pool_len[p];
			key = scramble_tail(pool_key[p], len);
		end else if (r < 93) begin
			len = LEN_W'($urandom_range(9, 15));
			key = {$urandom, $urandom};
		end else begin
			len = LEN_W'($urandom_range(0, 8));
			key = {$urandom, $urandom};
		end
		send(pick_action(), key, len, pick_slot());
	endtask

	task automatic run_random(input int unsigned n, input bit bool_bias);
		repeat (n) send_random(bool_bias);
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] slots,
			input logic bmode);
		drain();
		write_reg(REG_VALUE_LIMIT, limit);
		write_reg(REG_SLOT_COUNT, slots);
		write_reg(REG_BOOL_MODE, CFG_W'(bmode));
		write_reg(REG_SPARE, CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// receiver side stalls, plus one long hold-off on request
	initial begin
		int unsigned n;
		@(posedge clk);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_len[i] = LEN_W'($urandom_range(0, 8));
			pool_key[i] = {$urandom, $urandom};
		end
		pool_key[0] = BOOL_KEY_F;
		pool_len[0] = 1;
		pool_key[1] = BOOL_KEY_T;
		pool_len[1] = 1;
		pool_key[2] = '0;
		pool_len[2] = 2;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// unknown keys on an empty dictionary
		send(ACT_COUNT, {$urandom, $urandom}, 0, 0);
		send(ACT_TEST, '1, 8, 1023);
		send(ACT_CLEAR, '1, 8, 0);
		// empty key, both ends of the slot range
		send(ACT_SET, scramble_tail('0, 0), 0, 0);
		send(ACT_SET, scramble_tail('0, 0), 0, 1023);
		send(ACT_TEST, scramble_tail('0, 0), 0, 1023);
		send(ACT_COUNT, scramble_tail('0, 0), 0, 511);
		// full-width keys and same bytes with another length
		send(ACT_SET, '1, 8, 512);
		send(ACT_SET, '0, 8, 63);
		send(ACT_SET, scramble_tail(BOOL_KEY_F, 1), 1, 64);
		send(ACT_TEST, '0, 2, 64);
		// over-long keys never match
		send(ACT_SET, {$urandom, $urandom}, 9, 5);
		send(ACT_SET, {$urandom, $urandom}, 15, 5);
		send(ACT_TEST, '1, 15, 512);
		send(ACT_COUNT, '1, 15, 0);
		// clear then look again
		send(ACT_CLEAR, '1, 8, 512);
		send(ACT_TEST, '1, 8, 512);
		send(ACT_COUNT, '1, 8, 0);
		send(ACT_CLEAR, '0, 8, 63);
		send(ACT_COUNT, '0, 8, 1023);

		// zero limit: new keys rejected, known keys still work
		configure(0, 0, 1'b0);
		send(ACT_SET, {$urandom, $urandom}, 3, 7);
		send(ACT_SET, scramble_tail('0, 0), 0, 7);
		send(ACT_COUNT, scramble_tail('0, 0), 0, 7);
		run_random(100, 1'b0);

		// small dictionary, first stretch with no idling
		configure(6, 2047, 1'b0);
		quiet = 1'b1;
		run_random(100, 1'b0);
		quiet = 1'b0;
		run_random(100, 1'b0);

		// bool mode with an oversized limit
		configure(31, 1024, 1'b1);
		send(ACT_SET, scramble_tail(BOOL_KEY_T, 1), 1, 1023);
		send(ACT_SET, scramble_tail(64'h2, 1), 1, 3);
		send(ACT_TEST, scramble_tail(BOOL_KEY_F, 1), 1, 64);
		send(ACT_COUNT, scramble_tail(BOOL_KEY_T, 2), 2, 0);
		run_random(150, 1'b1);

		// dictionary grows to its capacity; long hold-off on the result side
		configure(31, 1000, 1'b0);
		run_random(100, 1'b0);
		hold_off = 1'b1;
		run_random(20, 1'b0);
		drain();
		run_random(130, 1'b0);

		configure(1, 1000, 1'b0);
		run_random(100, 1'b0);

		configure(16, 1024, 1'b1);
		run_random(100, 1'b1);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

[files.f]
sv/vbie_pkg.sv
sv/vbie_dict.sv
sv/value_bitmap_index_engine.sv
sim/vbie_checker.sv
sim/tb.sv
